[sv/rgbs_pkg.sv]
// Shared types, constants and helper functions of the RGB LED serializer.
package rgbs_pkg;

	localparam int NUM_LEDS    = 4;
	localparam int STORE_BYTES = NUM_LEDS * 3;
	localparam int PAIRS       = NUM_LEDS / 2;
	localparam int PAIR_W      = (PAIRS > 1) ? $clog2(PAIRS) : 1;
	localparam int PAIR_CNT_W  = $clog2(PAIRS + 1);
	localparam int ROW_W       = 24;
	localparam int TICK_W      = 8;

	localparam logic [2:0] BIT_FIRST = 3'd7;
	localparam logic [2:0] BYTE_LAST = 3'd5;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_REWIND = 2'd1,
		OP_STORE  = 2'd2,
		OP_START  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_PREFIX = 2'd1,
		PH_DATA   = 2'd2,
		PH_LOW    = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		CFG_PREFIX = 2'd0,
		CFG_DATA   = 2'd1,
		CFG_LOW    = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic write_rejected;
	} res_t;

	typedef struct packed {
		logic              en;
		logic [PAIR_W-1:0] addr;
		logic [ROW_W-1:0]  data;
	} mem_wr_t;

	function automatic logic [TICK_W:0] phase_len(
		input phase_t            ph,
		input logic [TICK_W-1:0] pre,
		input logic [TICK_W-1:0] dat,
		input logic [TICK_W-1:0] low
	);
		logic [TICK_W-1:0] v;
		unique case (ph)
			PH_PREFIX: v = pre;
			PH_DATA:   v = dat;
			default:   v = low;
		endcase
		return (v == '0) ? (TICK_W+1)'(1) : {1'b0, v};
	endfunction

	function automatic logic row_bit(
		input logic [ROW_W-1:0] row,
		input logic [2:0]       byte_idx,
		input logic [2:0]       bit_idx
	);
		logic [7:0] b;
		unique case (byte_idx)
			3'd0, 3'd3: b = row[23:16];
			3'd1, 3'd4: b = row[15:8];
			default:    b = row[7:0];
		endcase
		return b[bit_idx];
	endfunction

endpackage

[sv/rgbs_store.sv]
// Colour store: one row of green, red, blue per LED pair, registered read.
module rgbs_store (
	input  logic                             clk,
	input  rgbs_pkg::mem_wr_t                wr,
	input  logic [rgbs_pkg::PAIR_W-1:0]      rd_addr,
	output logic [rgbs_pkg::ROW_W-1:0]       rd_row
);

	logic [rgbs_pkg::ROW_W-1:0] mem [rgbs_pkg::PAIRS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_row <= mem[rd_addr];
	end

endmodule

[sv/rgbs_seq.sv]
// Command decode, bit timing sequencer and timing registers.
module rgbs_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  rgbs_pkg::op_t                 operation,
	input  logic [7:0]                    red,
	input  logic [7:0]                    green,
	input  logic [7:0]                    blue,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [7:0]                    cfg_data,
	input  logic [rgbs_pkg::ROW_W-1:0]    rd_row,
	output logic [rgbs_pkg::PAIR_W-1:0]   rd_addr,
	output rgbs_pkg::mem_wr_t             mem_wr,
	output rgbs_pkg::res_t                res
);

	rgbs_pkg::phase_t                    phase_q, phase_eff, phase_d;
	logic [rgbs_pkg::TICK_W-1:0]         cnt_q, cnt_eff, cnt_d;
	logic [2:0]                          bit_q, bit_eff, bit_d;
	logic [2:0]                          byte_q, byte_eff, byte_d;
	logic [rgbs_pkg::PAIR_W-1:0]         pair_q, pair_eff, pair_d;
	logic [rgbs_pkg::PAIR_CNT_W-1:0]     wpairs_q, wpairs_d;
	logic [rgbs_pkg::TICK_W-1:0]         prefix_q, data_q, low_q;
	logic                                busy, start, store_ok, rejected;
	logic                                tick_end, last_byte;

	assign busy = (phase_q != rgbs_pkg::PH_IDLE);

	always_comb begin
		wpairs_d = wpairs_q;
		rejected = 1'b0;
		start    = 1'b0;
		store_ok = 1'b0;
		unique case (operation)
			rgbs_pkg::OP_TICK: begin
			end
			rgbs_pkg::OP_REWIND: begin
				if (!busy) wpairs_d = '0;
			end
			rgbs_pkg::OP_STORE: begin
				if (busy || wpairs_q == rgbs_pkg::PAIR_CNT_W'(rgbs_pkg::PAIRS)) begin
					rejected = 1'b1;
				end else begin
					store_ok = 1'b1;
					wpairs_d = wpairs_q + rgbs_pkg::PAIR_CNT_W'(1);
				end
			end
			rgbs_pkg::OP_START: begin
				if (busy || wpairs_q == '0) rejected = 1'b1;
				else start = 1'b1;
			end
		endcase
	end

	assign phase_eff = start ? rgbs_pkg::PH_PREFIX : phase_q;
	assign cnt_eff   = start ? '0 : cnt_q;
	assign bit_eff   = start ? rgbs_pkg::BIT_FIRST : bit_q;
	assign byte_eff  = start ? 3'd0 : byte_q;
	assign pair_eff  = start ? '0 : pair_q;

	assign tick_end  = ({1'b0, cnt_eff} + (rgbs_pkg::TICK_W+1)'(1))
		>= rgbs_pkg::phase_len(phase_eff, prefix_q, data_q, low_q);
	assign last_byte = (byte_eff == rgbs_pkg::BYTE_LAST)
		&& (rgbs_pkg::PAIR_CNT_W'(pair_eff) + rgbs_pkg::PAIR_CNT_W'(1) == wpairs_q);

	// next phase
	always_comb begin
		phase_d = phase_eff;
		unique case (phase_eff)
			rgbs_pkg::PH_IDLE:   phase_d = rgbs_pkg::PH_IDLE;
			rgbs_pkg::PH_PREFIX: if (tick_end) phase_d = rgbs_pkg::PH_DATA;
			rgbs_pkg::PH_DATA:   if (tick_end) phase_d = rgbs_pkg::PH_LOW;
			rgbs_pkg::PH_LOW: begin
				if (tick_end) begin
					if (bit_eff == 3'd0 && last_byte) phase_d = rgbs_pkg::PH_IDLE;
					else phase_d = rgbs_pkg::PH_PREFIX;
				end
			end
		endcase
	end

	// position counters
	always_comb begin
		cnt_d  = cnt_eff;
		bit_d  = bit_eff;
		byte_d = byte_eff;
		pair_d = pair_eff;
		if (phase_eff != rgbs_pkg::PH_IDLE) begin
			cnt_d = tick_end ? '0 : rgbs_pkg::TICK_W'(cnt_eff + 8'd1);
			if (tick_end && phase_eff == rgbs_pkg::PH_LOW) begin
				if (bit_eff != 3'd0) begin
					bit_d = bit_eff - 3'd1;
				end else begin
					bit_d = rgbs_pkg::BIT_FIRST;
					if (byte_eff == rgbs_pkg::BYTE_LAST) begin
						byte_d = 3'd0;
						pair_d = last_byte ? '0 : pair_eff + rgbs_pkg::PAIR_W'(1);
					end else begin
						byte_d = byte_eff + 3'd1;
					end
				end
			end
		end
	end

	// outputs
	always_comb begin
		res.busy_res       = (phase_eff != rgbs_pkg::PH_IDLE);
		res.write_rejected = rejected;
		unique case (phase_eff)
			rgbs_pkg::PH_PREFIX: res.line_level = 1'b1;
			rgbs_pkg::PH_DATA:   res.line_level = rgbs_pkg::row_bit(rd_row, byte_eff, bit_eff);
			default:             res.line_level = 1'b0;
		endcase
		mem_wr.en   = accept && store_ok;
		mem_wr.addr = wpairs_q[rgbs_pkg::PAIR_W-1:0];
		mem_wr.data = {green, red, blue};
	end

	assign rd_addr = pair_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= rgbs_pkg::PH_IDLE;
			cnt_q    <= '0;
			bit_q    <= rgbs_pkg::BIT_FIRST;
			byte_q   <= 3'd0;
			pair_q   <= '0;
			wpairs_q <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			cnt_q    <= cnt_d;
			bit_q    <= bit_d;
			byte_q   <= byte_d;
			pair_q   <= pair_d;
			wpairs_q <= wpairs_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= 8'd2;
			data_q   <= 8'd7;
			low_q    <= 8'd12;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rgbs_pkg::CFG_PREFIX: prefix_q <= cfg_data;
				rgbs_pkg::CFG_DATA:   data_q   <= cfg_data;
				rgbs_pkg::CFG_LOW:    low_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	a_busy_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (wpairs_q != '0))
		else $error("sending with empty store");

	a_pair_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (rgbs_pkg::PAIR_CNT_W'(pair_q) < wpairs_q))
		else $error("send row beyond written rows");

	a_idle_rewound: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> (pair_q == '0 && byte_q == 3'd0 && bit_q == rgbs_pkg::BIT_FIRST))
		else $error("send position not rewound while idle");

	a_byte_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_q <= rgbs_pkg::BYTE_LAST)
		else $error("byte in pair out of range");

	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr.en |-> !busy)
		else $error("store written during send");

endmodule

[sv/rgbs_outbuf.sv]
// Result register with skid stage.
module rgbs_outbuf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  rgbs_pkg::res_t res_in,
	input  logic           res_stall,
	output logic           res_valid,
	output rgbs_pkg::res_t res_out,
	output logic           cmd_stall
);

	logic           out_v_q, skid_v_q;
	rgbs_pkg::res_t out_q, skid_q;
	logic           take;

	assign take      = out_v_q && !res_stall;
	assign res_valid = out_v_q;
	assign res_out   = out_q;
	assign cmd_stall = skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take) skid_v_q <= 1'b0;
		end else if (accept) begin
			if (out_v_q && !take) skid_v_q <= 1'b1;
			else out_v_q <= 1'b1;
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) out_q <= skid_q;
		end else if (accept) begin
			if (out_v_q && !take) skid_q <= res_in;
			else out_q <= res_in;
		end
	end

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid holds a result ahead of the output register");

	a_no_accept_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> !accept)
		else $error("request accepted with both stages full");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && take) |=> (out_v_q && !skid_v_q))
		else $error("skid result lost on drain");

endmodule

[sv/rgb_led_one_wire_serializer.sv]
// Top level of the one-wire RGB LED serializer.
// A result is registered in the output register, or in the skid stage while that is held.
// One request per cycle while cmd_stall is low; the colour store has one write and one read port.
// The registered read of the current LED pair row is issued every cycle, ahead of each data phase.
// Reset: asynchronous, active low; sender idle, write position zero, timing 2/7/12 ticks.
// The colour store is not cleared; only written rows are ever sent.
module rgb_led_one_wire_serializer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_stall,
	input  logic [1:0] operation,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output logic       res_valid,
	input  logic       res_stall,
	output logic       line_level,
	output logic       busy_res,
	output logic       write_rejected,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	logic                            accept;
	logic [rgbs_pkg::ROW_W-1:0]      rd_row;
	logic [rgbs_pkg::PAIR_W-1:0]     rd_addr;
	rgbs_pkg::mem_wr_t               mem_wr;
	rgbs_pkg::res_t                  res_next, res_out;

	assign accept = cmd_valid && !cmd_stall;

	rgbs_store u_store (
		.clk     (clk),
		.wr      (mem_wr),
		.rd_addr (rd_addr),
		.rd_row  (rd_row)
	);

	rgbs_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.operation (rgbs_pkg::op_t'(operation)),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rd_row    (rd_row),
		.rd_addr   (rd_addr),
		.mem_wr    (mem_wr),
		.res       (res_next)
	);

	rgbs_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.res_in    (res_next),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.res_out   (res_out),
		.cmd_stall (cmd_stall)
	);

	assign line_level     = res_out.line_level;
	assign busy_res       = res_out.busy_res;
	assign write_rejected = res_out.write_rejected;

endmodule

[verif/tb.sv]
// Self-checking testbench of the one-wire RGB LED serializer: directed table, then random traffic.
`timescale 1ns / 100ps

module tb;
	import rgbs_pkg::*;

	localparam logic [1:0] CFG_NONE    = 2'd3;
	localparam int         CYCLE_LIMIT = 500000;
	localparam int         HOLD_CYCLES = 150;
	localparam int         PHASES      = 8;

	typedef struct {
		op_t        op;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       typed;
		res_t       want;
	} dir_row_t;

	typedef struct {
		logic [7:0] pre;
		logic [7:0] dat;
		logic [7:0] low;
		int         items;
	} timing_t;

	logic       clk;
	logic       arst_n;
	logic       cmd_valid;
	logic       cmd_stall;
	logic [1:0] operation;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       res_valid;
	logic       res_stall;
	logic       line_level;
	logic       busy_res;
	logic       write_rejected;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	// line model state
	logic [7:0] colours [STORE_BYTES];
	logic [3:0] wr_pos     = '0;
	logic [3:0] byte_pos   = '0;
	logic [2:0] bit_pos    = BIT_FIRST;
	phase_t     line_phase = PH_IDLE;
	logic [7:0] tick_cnt   = '0;
	logic [7:0] prefix_len = 8'd2;
	logic [7:0] data_len   = 8'd7;
	logic [7:0] low_len    = 8'd12;

	res_t line_due [$];
	int   faults      = 0;
	int   cycle_count = 0;
	logic idling      = 1'b1;
	logic hold_req    = 1'b0;
	int   hold_left   = 0;
	int   stall_left  = 0;

	dir_row_t dir_rows [14] = '{
		'{OP_TICK,   8'h00, 8'h00, 8'h00, 1'b1, 3'b000},
		'{OP_START,  8'h00, 8'h00, 8'h00, 1'b1, 3'b001},
		'{OP_STORE,  8'hFF, 8'hFF, 8'hFF, 1'b1, 3'b000},
		'{OP_REWIND, 8'h00, 8'h00, 8'h00, 1'b1, 3'b000},
		'{OP_STORE,  8'hFF, 8'h00, 8'hA5, 1'b1, 3'b000},
		'{OP_STORE,  8'h00, 8'hFF, 8'h5A, 1'b1, 3'b000},
		'{OP_STORE,  8'h12, 8'h34, 8'h56, 1'b1, 3'b001},
		'{OP_START,  8'h00, 8'h00, 8'h00, 1'b1, 3'b110},
		'{OP_START,  8'h00, 8'h00, 8'h00, 1'b1, 3'b111},
		'{OP_STORE,  8'h77, 8'h88, 8'h99, 1'b1, 3'b011},
		'{OP_REWIND, 8'h00, 8'h00, 8'h00, 1'b0, 3'b000},
		'{OP_TICK,   8'hFF, 8'hFF, 8'hFF, 1'b0, 3'b000},
		'{OP_TICK,   8'h00, 8'h00, 8'h00, 1'b0, 3'b000},
		'{OP_TICK,   8'h00, 8'h00, 8'h00, 1'b0, 3'b000}
	};

	timing_t timings [PHASES];

	rgb_led_one_wire_serializer dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd_stall      (cmd_stall),
		.operation      (operation),
		.red            (red),
		.green          (green),
		.blue           (blue),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.line_level     (line_level),
		.busy_res       (busy_res),
		.write_rejected (write_rejected),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic res_t advance_line(input op_t op, input logic [7:0] r, g, b);
		res_t       o;
		logic       busy;
		logic [8:0] lim;
		o    = '0;
		busy = (line_phase != PH_IDLE);
		case (op)
			OP_REWIND: begin
				if (!busy)
					wr_pos = '0;
			end
			OP_STORE: begin
				if (busy || int'(wr_pos) + 6 > STORE_BYTES) begin
					o.write_rejected = 1'b1;
				end else begin
					for (int k = 0; k < 2; k++) begin
						colours[wr_pos]        = g;
						colours[wr_pos + 4'd1] = r;
						colours[wr_pos + 4'd2] = b;
						wr_pos = wr_pos + 4'd3;
					end
				end
			end
			OP_START: begin
				if (busy || wr_pos == 4'd0) begin
					o.write_rejected = 1'b1;
				end else begin
					line_phase = PH_PREFIX;
					tick_cnt   = '0;
					byte_pos   = '0;
					bit_pos    = BIT_FIRST;
				end
			end
			default: ;
		endcase
		if (line_phase != PH_IDLE) begin
			o.busy_res = 1'b1;
			case (line_phase)
				PH_PREFIX: o.line_level = 1'b1;
				PH_DATA:   o.line_level = colours[byte_pos][bit_pos];
				default:   o.line_level = 1'b0;
			endcase
			case (line_phase)
				PH_PREFIX: lim = {1'b0, prefix_len};
				PH_DATA:   lim = {1'b0, data_len};
				default:   lim = {1'b0, low_len};
			endcase
			if (lim == 9'd0)
				lim = 9'd1;
			tick_cnt = tick_cnt + 8'd1;
			if ({1'b0, tick_cnt} >= lim) begin
				tick_cnt = '0;
				case (line_phase)
					PH_PREFIX: line_phase = PH_DATA;
					PH_DATA:   line_phase = PH_LOW;
					default: begin
						if (bit_pos != 3'd0) begin
							bit_pos    = bit_pos - 3'd1;
							line_phase = PH_PREFIX;
						end else begin
							bit_pos  = BIT_FIRST;
							byte_pos = byte_pos + 4'd1;
							if (byte_pos >= wr_pos) begin
								byte_pos   = '0;
								line_phase = PH_IDLE;
							end else begin
								line_phase = PH_PREFIX;
							end
						end
					end
				endcase
			end
		end
		return o;
	endfunction

	function automatic int gap_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic op_t pick_op();
		int r;
		r = $urandom_range(0, 99);
		if (line_phase != PH_IDLE)
			return (r < 6) ? op_t'($urandom_range(0, 3)) : OP_TICK;
		if (r < 10)
			return op_t'($urandom_range(0, 3));
		if (r < 25)
			return OP_REWIND;
		if (wr_pos == 4'd0)
			return OP_STORE;
		if (int'(wr_pos) + 6 <= STORE_BYTES)
			return (r < 60) ? OP_STORE : OP_START;
		return (r < 32) ? OP_STORE : OP_START;
	endfunction

	task automatic push_cmd(input op_t op, input logic [7:0] r, g, b,
			input logic typed, input res_t want);
		int   n;
		res_t got;
		n = (idling && $urandom_range(0, 99) < 25) ? gap_cycles() : 0;
		if (n > 0) begin
			cmd_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		operation <= op;
		red       <= r;
		green     <= g;
		blue      <= b;
		do @(posedge clk); while (cmd_stall !== 1'b0);
		got = advance_line(op, r, g, b);
		line_due.push_back(typed ? want : got);
	endtask

	task automatic drain();
		cmd_valid <= 1'b0;
		while (line_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_put(input logic [1:0] idx, input logic [7:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		case (idx)
			CFG_PREFIX: prefix_len = v;
			CFG_DATA:   data_len   = v;
			CFG_LOW:    low_len    = v;
			default: ;
		endcase
	endtask

	task automatic cmp_bit(input string name, input logic want, input logic got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %b, got %b", $time, name, want, got);
			faults++;
		end
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid === 1'b1 && res_stall === 1'b0) begin
			if (line_due.size() == 0) begin
				$display("%0t: unexpected result, line %b busy %b rejected %b",
					$time, line_level, busy_res, write_rejected);
				faults++;
			end else begin
				want = line_due.pop_front();
				cmp_bit("line_level", want.line_level, line_level);
				cmp_bit("busy_res", want.busy_res, busy_res);
				cmp_bit("write_rejected", want.write_rejected, write_rejected);
			end
		end
	end

	initial begin
		res_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
				if (idling && $urandom_range(0, 99) < 20)
					stall_left = gap_cycles();
			end
		end
	end

	initial begin
		cmd_valid = 1'b0;
		operation = OP_TICK;
		red       = '0;
		green     = '0;
		blue      = '0;
		cfg_we    = 1'b0;
		cfg_index = CFG_PREFIX;
		cfg_data  = '0;
		arst_n    = 1'b0;

		timings[0] = '{8'd1,   8'd1,   8'd1,   150};
		timings[1] = '{8'd0,   8'd0,   8'd0,   150};
		timings[2] = '{8'd255, 8'd255, 8'd255, 60};
		timings[3] = '{8'd3,   8'd2,   8'd1,   110};
		timings[4] = '{8'd1,   8'd4,   8'd2,   110};
		timings[5] = '{8'd2,   8'd7,   8'd12,  60};
		for (int p = 6; p < PHASES; p++)
			timings[p] = '{8'($urandom_range(0, 4)), 8'($urandom_range(0, 4)),
				8'($urandom_range(0, 4)), 60};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			push_cmd(dir_rows[i].op, dir_rows[i].r, dir_rows[i].g, dir_rows[i].b,
				dir_rows[i].typed, dir_rows[i].want);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			cfg_put(CFG_PREFIX, timings[p].pre);
			cfg_put(CFG_DATA, timings[p].dat);
			cfg_put(CFG_LOW, timings[p].low);
			cfg_put(CFG_NONE, 8'($urandom_range(0, 255)));
			@(posedge clk);
			cfg_we <= 1'b0;
			idling = (p % 2 == 0);
			if (p == 1)
				hold_req = 1'b1;
			for (int n = 0; n < timings[p].items; n++)
				push_cmd(pick_op(), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 1'b0, '0);
		end

		drain();
		repeat (8) @(posedge clk);
		if (faults == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[files.f]
sv/rgbs_pkg.sv
sv/rgbs_store.sv
sv/rgbs_seq.sv
sv/rgbs_outbuf.sv
sv/rgb_led_one_wire_serializer.sv
verif/tb.sv
